@@ rtl/core/ccdcal_pkg.sv @@
// shared types and constants of the ccd pixel calibration unit
`timescale 1ns / 1ps
package ccdcal_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_INVERSE_GAIN = 2'd0;
  localparam logic [1:0] REG_READ_NOISE   = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] INV_GAIN_RST   = 16'd4096;
  localparam logic [15:0] READ_NOISE_RST = 16'd256;
  localparam logic [12:0] IMG_WIDTH_RST  = 13'd4096;

  // result limits
  localparam logic [34:0] RED_POS_MAX = 35'd8388607;
  localparam logic [34:0] RED_NEG_MAX = 35'd8388608;
  localparam logic [19:0] ERR_MAX     = 20'hFFFFF;
  localparam logic [52:0] SUM_CLAMP   = 53'h800_0000_0000;

  // pipeline widths
  localparam int unsigned DIV1_QW = 35;
  localparam int unsigned DIV2_QW = 40;
  localparam int unsigned SQRT_W  = 20;

  // input item
  typedef struct packed {
    logic        mode;
    logic [11:0] column;
    logic [15:0] raw_value;
    logic [15:0] dark_value;
    logic [15:0] flat_value;
    logic [15:0] dark_error;
    logic [15:0] flat_error;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [23:0] reduced_value;
    logic [19:0]        error_value;
    logic               flat_zero;
    logic               saturated;
    logic               column_error;
  } out_t;

  // one column entry of the calibration memory
  typedef struct packed {
    logic [15:0] dark;
    logic [15:0] flat;
    logic [15:0] dark_err;
    logic [15:0] flat_err;
  } cal_t;

  // side data that travels with the first division
  typedef struct packed {
    logic [15:0] raw;
    logic [15:0] flat;
    logic [15:0] dark_err;
    logic [15:0] flat_err;
    logic        neg;
    logic        cerr;
    logic        fz;
  } pre_t;

  // side data that travels with the second division and the square root
  typedef struct packed {
    logic [23:0] red;
    logic        sat;
    logic        ovf;
    logic        cerr;
    logic        fz;
  } post_t;

endpackage

@@ rtl/core/ccdcal_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ccdcal_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ccdcal_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ccdcal_div_pipe #(
  parameter int unsigned DEN_W = 16,
  parameter int unsigned QUO_W = 35,
  parameter int unsigned TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [DEN_W-1:0] in_rem,
  input  wire logic [QUO_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_vld,
  output logic      [QUO_W-1:0] out_quo,
  output logic      [TAG_W-1:0] out_tag
);

  logic             vld_r  [1:QUO_W];
  logic [DEN_W-1:0] rem_r  [1:QUO_W];
  logic [QUO_W-1:0] work_r [1:QUO_W];
  logic [DEN_W-1:0] den_r  [1:QUO_W];
  logic [TAG_W-1:0] tag_r  [1:QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             cur_vld;
    logic [DEN_W-1:0] cur_rem;
    logic [QUO_W-1:0] cur_work;
    logic [DEN_W-1:0] cur_den;
    logic [TAG_W-1:0] cur_tag;
    logic [DEN_W:0]   wide;
    logic [DEN_W:0]   diff;
    logic             ge;

    // stage input
    if (k == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = in_rem;
      assign cur_work = in_num;
      assign cur_den  = in_den;
      assign cur_tag  = in_tag;
    end else begin : g_next
      assign cur_vld  = vld_r[k];
      assign cur_rem  = rem_r[k];
      assign cur_work = work_r[k];
      assign cur_den  = den_r[k];
      assign cur_tag  = tag_r[k];
    end

    // trial subtraction
    assign wide = {cur_rem, cur_work[QUO_W-1]};
    assign ge   = (wide >= {1'b0, cur_den});
    assign diff = wide - {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DEN_W-1:0] : wide[DEN_W-1:0];
        work_r[k+1] <= {cur_work[QUO_W-2:0], ge};
        den_r[k+1]  <= cur_den;
        tag_r[k+1]  <= cur_tag;
      end
    end
  end

  assign out_vld = vld_r[QUO_W];
  assign out_quo = work_r[QUO_W];
  assign out_tag = tag_r[QUO_W];

endmodule
`default_nettype wire

@@ rtl/core/ccdcal_sqrt_pipe.sv @@
// pipelined restoring integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ccdcal_sqrt_pipe #(
  parameter int unsigned RES_W = 20,
  parameter int unsigned TAG_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic [2*RES_W-1:0] in_rad,
  input  wire logic [TAG_W-1:0]   in_tag,
  output logic                    out_vld,
  output logic      [RES_W-1:0]   out_root,
  output logic      [TAG_W-1:0]   out_tag
);

  logic               vld_r  [1:RES_W];
  logic [RES_W:0]     rem_r  [1:RES_W];
  logic [RES_W-1:0]   root_r [1:RES_W];
  logic [2*RES_W-1:0] rad_r  [1:RES_W];
  logic [TAG_W-1:0]   tag_r  [1:RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic               cur_vld;
    logic [RES_W:0]     cur_rem;
    logic [RES_W-1:0]   cur_root;
    logic [2*RES_W-1:0] cur_rad;
    logic [TAG_W-1:0]   cur_tag;
    logic [RES_W+2:0]   wide;
    logic [RES_W+2:0]   trial;
    logic [RES_W+2:0]   diff;
    logic               ge;

    // stage input
    if (k == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = in_rad;
      assign cur_tag  = in_tag;
    end else begin : g_next
      assign cur_vld  = vld_r[k];
      assign cur_rem  = rem_r[k];
      assign cur_root = root_r[k];
      assign cur_rad  = rad_r[k];
      assign cur_tag  = tag_r[k];
    end

    // bring down two radicand bits and try root*4+1
    assign wide  = {cur_rem, cur_rad[2*RES_W-1 -: 2]};
    assign trial = {1'b0, cur_root, 2'b01};
    assign ge    = (wide >= trial);
    assign diff  = wide - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[RES_W:0] : wide[RES_W:0];
        root_r[k+1] <= {cur_root[RES_W-2:0], ge};
        rad_r[k+1]  <= {cur_rad[2*RES_W-3:0], 2'b00};
        tag_r[k+1]  <= cur_tag;
      end
    end
  end

  assign out_vld  = vld_r[RES_W];
  assign out_root = root_r[RES_W];
  assign out_tag  = tag_r[RES_W];

endmodule
`default_nettype wire

@@ rtl/core/ccd_dark_flat_pixel_calibration_unit.sv @@
// top level of the ccd dark subtraction and flat field calibration unit
//
//  channel | ports                                | item
//  --------+--------------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data          | load entry or pixel
//  result  | out_valid, out_ready, out_data       | calibrated pixel (pixels only)
//  config  | cfg_we, cfg_index, cfg_wdata         | register write, no wait
//
// one item is taken every cycle unless the pipe stalls; a pixel result passes
// through the ram read, two restoring dividers (35 and 40 stages), four
// arithmetic stages, a 20 stage square root and the output register.
// the whole pipe moves as one and stalls only while a result waits in the
// output register; in_ready follows that. loads write the column ram at once.
// reset is synchronous, active low, clears valid bits and resets configuration.
`timescale 1ns / 1ps
`default_nettype none
module ccd_dark_flat_pixel_calibration_unit #(
  parameter int unsigned NUM_COLUMNS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ccdcal_pkg::in_t    in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ccdcal_pkg::out_t        out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(NUM_COLUMNS);
  localparam logic [16:0] NUM_COL_L = 17'(NUM_COLUMNS);

  // configuration registers
  logic [15:0] inv_gain_r;
  logic [15:0] read_noise_r;
  logic [12:0] img_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_gain_r   <= ccdcal_pkg::INV_GAIN_RST;
      read_noise_r <= ccdcal_pkg::READ_NOISE_RST;
      img_width_r  <= ccdcal_pkg::IMG_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccdcal_pkg::REG_INVERSE_GAIN: inv_gain_r   <= cfg_wdata;
        ccdcal_pkg::REG_READ_NOISE:   read_noise_r <= cfg_wdata;
        ccdcal_pkg::REG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // pipe advance
  logic out_valid_r;
  logic en;
  logic accept;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // column decode and ram access
  logic [16:0]       col_ext;
  logic              col_in_mem;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  ccdcal_pkg::cal_t  ram_wdata;
  ccdcal_pkg::cal_t  ram_rdata;

  assign col_ext    = {5'b0, in_data.column};
  assign col_in_mem = (col_ext < NUM_COL_L);
  assign ram_addr   = col_ext[ADDR_W-1:0];
  assign ram_we     = accept && !in_data.mode && col_in_mem;
  assign ram_re     = accept && in_data.mode;
  assign ram_wdata  = '{dark: in_data.dark_value, flat: in_data.flat_value,
                        dark_err: in_data.dark_error, flat_err: in_data.flat_error};

  ccdcal_ram #(
    .WIDTH ($bits(ccdcal_pkg::cal_t)),
    .DEPTH (NUM_COLUMNS)
  ) u_cal_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // stage 1: pixel waits for its column entry
  logic        s1_vld_r;
  logic [15:0] s1_raw_r;
  logic        s1_cerr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw_r  <= in_data.raw_value;
      s1_cerr_r <= ({1'b0, in_data.column} >= img_width_r) || !col_in_mem;
    end
  end

  // dark subtraction feeding the first divider
  logic             s1_neg;
  logic [15:0]      s1_mag;
  ccdcal_pkg::pre_t s1_tag;

  assign s1_neg = s1_raw_r < ram_rdata.dark;
  assign s1_mag = s1_neg ? (ram_rdata.dark - s1_raw_r) : (s1_raw_r - ram_rdata.dark);
  assign s1_tag = '{raw: s1_raw_r, flat: ram_rdata.flat, dark_err: ram_rdata.dark_err,
                    flat_err: ram_rdata.flat_err, neg: s1_neg, cerr: s1_cerr_r,
                    fz: !s1_cerr_r && (ram_rdata.flat == 16'd0)};

  logic                           d1_vld;
  logic [ccdcal_pkg::DIV1_QW-1:0] d1_quo;
  ccdcal_pkg::pre_t               d1_tag;

  ccdcal_div_pipe #(
    .DEN_W (16),
    .QUO_W (ccdcal_pkg::DIV1_QW),
    .TAG_W ($bits(ccdcal_pkg::pre_t))
  ) u_div_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s1_vld_r),
    .in_rem  (16'd0),
    .in_num  ({s1_mag, 19'd0}),
    .in_den  (ram_rdata.flat),
    .in_tag  (s1_tag),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_tag (d1_tag)
  );

  // stage 2: rounding, saturation of the reduced value, first products
  logic [35:0] d1_round;
  logic [34:0] d1_mag;
  logic        d1_clip;
  logic [23:0] d1_msat;

  assign d1_round = {1'b0, d1_quo} + 36'd1;
  assign d1_mag   = d1_round[35:1];
  assign d1_clip  = d1_tag.neg ? (d1_mag > ccdcal_pkg::RED_NEG_MAX)
                               : (d1_mag > ccdcal_pkg::RED_POS_MAX);
  assign d1_msat  = d1_clip ? (d1_tag.neg ? 24'h800000 : 24'h7FFFFF) : d1_mag[23:0];

  logic        s2_vld_r;
  logic [23:0] s2_red_r;
  logic [23:0] s2_msat_r;
  logic        s2_sat_r;
  logic [31:0] s2_pg_r;
  logic [31:0] s2_rn2_r;
  logic [31:0] s2_de2_r;
  logic [15:0] s2_fe_r;
  logic [15:0] s2_flat_r;
  logic        s2_cerr_r;
  logic        s2_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_red_r  <= d1_tag.neg ? (24'd0 - d1_msat) : d1_msat;
      s2_msat_r <= d1_msat;
      s2_sat_r  <= d1_clip;
      s2_pg_r   <= 32'(d1_tag.raw * inv_gain_r);
      s2_rn2_r  <= 32'(read_noise_r * read_noise_r);
      s2_de2_r  <= 32'(d1_tag.dark_err * d1_tag.dark_err);
      s2_fe_r   <= d1_tag.flat_err;
      s2_flat_r <= d1_tag.flat;
      s2_cerr_r <= d1_tag.cerr;
      s2_fz_r   <= d1_tag.fz;
    end
  end

  // stage 3: flat error product and partial variance sum
  logic        s3_vld_r;
  logic [39:0] s3_mfe_r;
  logic [32:0] s3_ab_r;
  logic [23:0] s3_red_r;
  logic        s3_sat_r;
  logic [15:0] s3_flat_r;
  logic        s3_cerr_r;
  logic        s3_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mfe_r  <= 40'(s2_msat_r * s2_fe_r);
      s3_ab_r   <= 33'(s2_pg_r[31:4]) + 33'(s2_rn2_r[31:8]) + 33'(s2_de2_r);
      s3_red_r  <= s2_red_r;
      s3_sat_r  <= s2_sat_r;
      s3_flat_r <= s2_flat_r;
      s3_cerr_r <= s2_cerr_r;
      s3_fz_r   <= s2_fz_r;
    end
  end

  // stage 4: square of the scaled reduced term
  logic        s4_vld_r;
  logic [61:0] s4_tt_r;
  logic [32:0] s4_ab_r;
  logic [23:0] s4_red_r;
  logic        s4_sat_r;
  logic [15:0] s4_flat_r;
  logic        s4_cerr_r;
  logic        s4_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tt_r   <= 62'(s3_mfe_r[39:9] * s3_mfe_r[39:9]);
      s4_ab_r   <= s3_ab_r;
      s4_red_r  <= s3_red_r;
      s4_sat_r  <= s3_sat_r;
      s4_flat_r <= s3_flat_r;
      s4_cerr_r <= s3_cerr_r;
      s4_fz_r   <= s3_fz_r;
    end
  end

  // stage 5: full variance sum with clamp
  logic [52:0] s4_sum;
  assign s4_sum = 53'(s4_ab_r) + 53'(s4_tt_r[61:10]);

  logic        s5_vld_r;
  logic [43:0] s5_sum_r;
  logic [23:0] s5_red_r;
  logic        s5_sat_r;
  logic [15:0] s5_flat_r;
  logic        s5_cerr_r;
  logic        s5_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sum_r  <= (s4_sum > ccdcal_pkg::SUM_CLAMP) ? ccdcal_pkg::SUM_CLAMP[43:0]
                                                    : s4_sum[43:0];
      s5_red_r  <= s4_red_r;
      s5_sat_r  <= s4_sat_r;
      s5_flat_r <= s4_flat_r;
      s5_cerr_r <= s4_cerr_r;
      s5_fz_r   <= s4_fz_r;
    end
  end

  // variance over flat; a quotient of 2^40 or more would clip the error anyway
  logic              s5_ovf;
  ccdcal_pkg::post_t s5_tag;

  assign s5_ovf = (s5_sum_r >= {2'b00, s5_flat_r, 26'd0});
  assign s5_tag = '{red: s5_red_r, sat: s5_sat_r, ovf: s5_ovf,
                    cerr: s5_cerr_r, fz: s5_fz_r};

  logic                           d2_vld;
  logic [ccdcal_pkg::DIV2_QW-1:0] d2_quo;
  ccdcal_pkg::post_t              d2_tag;

  ccdcal_div_pipe #(
    .DEN_W (16),
    .QUO_W (ccdcal_pkg::DIV2_QW),
    .TAG_W ($bits(ccdcal_pkg::post_t))
  ) u_div_var (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s5_vld_r),
    .in_rem  (s5_sum_r[41:26]),
    .in_num  ({s5_sum_r[25:0], 14'd0}),
    .in_den  (s5_flat_r),
    .in_tag  (s5_tag),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_tag (d2_tag)
  );

  // square root of the variance
  logic                          sq_vld;
  logic [ccdcal_pkg::SQRT_W-1:0] sq_root;
  ccdcal_pkg::post_t             sq_tag;

  ccdcal_sqrt_pipe #(
    .RES_W (ccdcal_pkg::SQRT_W),
    .TAG_W ($bits(ccdcal_pkg::post_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d2_vld),
    .in_rad   (d2_quo),
    .in_tag   (d2_tag),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // result assembly
  ccdcal_pkg::out_t res_nxt;
  ccdcal_pkg::out_t out_data_r;

  always_comb begin
    res_nxt = '0;
    priority if (sq_tag.cerr) begin
      res_nxt.column_error = 1'b1;
    end else if (sq_tag.fz) begin
      res_nxt.flat_zero = 1'b1;
    end else begin
      res_nxt.reduced_value = sq_tag.red;
      res_nxt.error_value   = sq_tag.ovf ? ccdcal_pkg::ERR_MAX : sq_root;
      res_nxt.saturated     = sq_tag.sat || sq_tag.ovf;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a waiting result holds the whole pipe
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // one item per cycle: never a load and a pixel access together
  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ram written and read in one cycle");

  // column error gives zero results and no other flag
  a_cerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.column_error |->
      out_data_r.reduced_value == 24'sd0 && out_data_r.error_value == 20'd0 &&
      !out_data_r.flat_zero && !out_data_r.saturated)
    else $error("column error result not cleared");

  // zero flat gives zero results and no clipping
  a_fz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.flat_zero |->
      out_data_r.reduced_value == 24'sd0 && out_data_r.error_value == 20'd0 &&
      !out_data_r.saturated && !out_data_r.column_error)
    else $error("zero flat result not cleared");
`endif

endmodule
`default_nettype wire
